@@ design/keyed_fifo_with_cancel_unit_assert.svh @@
// Assertion macros for the keyed FIFO with cancel.
// Used by the top level; expects clk and rst_n in scope.
`ifndef KEYED_FIFO_WITH_CANCEL_UNIT_ASSERT_SVH
`define KEYED_FIFO_WITH_CANCEL_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define KFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed fifo check failed");

// antecedent implies consequent in the next cycle
`define KFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed fifo check failed");

`endif

@@ design/kfc_pkg.sv @@
// Package for the keyed FIFO with cancel: word types, codes, defaults.
// No dependencies.
`default_nettype none
package kfc_pkg;

    localparam int QUEUE_SLOTS_DEF = 64;
    localparam int KEY_BITS_DEF    = 16;
    localparam int MAX_POP_DEF     = 16;

    // operation codes
    localparam logic [2:0] FN_ENQ   = 3'd0;
    localparam logic [2:0] FN_CAN   = 3'd1;
    localparam logic [2:0] FN_REQ   = 3'd2;
    localparam logic [2:0] FN_POPEX = 3'd3;
    localparam logic [2:0] FN_POPUP = 3'd4;
    localparam logic [2:0] FN_QRY   = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_DUP    = 3'd1;
    localparam logic [2:0] ST_ABSENT = 3'd2;
    localparam logic [2:0] ST_FEW    = 3'd3;
    localparam logic [2:0] ST_FULL   = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] player_id;
        logic [4:0]  pop_count;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        has_player;
        logic [15:0] popped_id;
        logic        is_waiting;
        logic [6:0]  queue_size;
        logic        last;
    } out_word_t;

endpackage
`default_nettype wire

@@ design/kfc_front.sv @@
// Front end: accepts command words, saturates the pop count, queues them.
// Depends on kfc_pkg.
`default_nettype none
module kfc_front #(
    parameter int MAX_POP = kfc_pkg::MAX_POP_DEF,
    parameter int CW      = $clog2(MAX_POP + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire kfc_pkg::in_word_t cmd,
    output logic                  q_valid,
    output kfc_pkg::in_word_t     q_word,
    output logic [CW-1:0]         q_count,
    input  wire logic             q_pop
);

    kfc_pkg::in_word_t word_reg [2];
    logic [CW-1:0]     cnt_reg [2];
    logic              wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0]        fill_reg, fill_next;
    logic              push;
    logic [CW-1:0]     sat_cnt;

    // clamp the requested count to the largest pop
    always_comb
    begin
        if ({2'b00, cmd.pop_count} > 7'(MAX_POP))
            sat_cnt = CW'(MAX_POP);
        else
            sat_cnt = CW'(cmd.pop_count);
    end

    assign busy    = fill_reg[1];
    assign push    = start && !busy;
    assign q_valid = fill_reg != 2'd0;
    assign q_word  = word_reg[rd_reg];
    assign q_count = cnt_reg[rd_reg];

    // advance pointers and fill count
    always_comb
    begin
        wr_next   = push ? !wr_reg : wr_reg;
        rd_next   = (q_pop && q_valid) ? !rd_reg : rd_reg;
        fill_next = fill_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    // hold queued words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            word_reg[wr_reg] <= cmd;
            cnt_reg[wr_reg]  <= sat_cnt;
        end
    end

endmodule
`default_nettype wire

@@ design/kfc_back.sv @@
// Back end: cell row with parallel key compare, executes queued commands.
// Depends on kfc_pkg.
`default_nettype none
module kfc_back #(
    parameter int QUEUE_SLOTS = kfc_pkg::QUEUE_SLOTS_DEF,
    parameter int KEY_BITS    = kfc_pkg::KEY_BITS_DEF,
    parameter int MAX_POP     = kfc_pkg::MAX_POP_DEF,
    parameter int CW          = $clog2(MAX_POP + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire kfc_pkg::in_word_t q_word,
    input  wire logic [CW-1:0]     q_count,
    output logic                   q_pop,
    output logic                   done,
    output kfc_pkg::out_word_t     result
);

    localparam int OW   = $clog2(QUEUE_SLOTS + 1);
    localparam int CMPW = (OW > CW) ? OW : CW;

    typedef enum logic {S_IDLE, S_POP} state_t;

    state_t             state_reg, state_next;
    logic [KEY_BITS-1:0] cell_reg [QUEUE_SLOTS];
    logic [KEY_BITS-1:0] cell_next [QUEUE_SLOTS];
    logic [OW-1:0]      occ_reg, occ_next, final_reg, final_next;
    logic [CW-1:0]      remain_reg, remain_next;
    kfc_pkg::out_word_t res_reg, res_next;
    logic               done_reg, done_next;

    logic [KEY_BITS+15:0] key_ext;
    logic [KEY_BITS-1:0]  key;
    logic [QUEUE_SLOTS-1:0] match, after;
    logic                 found, few;
    logic [CMPW-1:0]      occ_w, n_w, neff;
    logic [KEY_BITS+15:0] head_ext;
    logic [15:0]          head_id;
    logic [OW+6:0]        fin_ext, occn_ext;

    assign key_ext  = {{KEY_BITS{1'b0}}, q_word.player_id};
    assign key      = key_ext[KEY_BITS-1:0];
    assign head_ext = {16'd0, cell_reg[0]};
    assign head_id  = head_ext[15:0];
    assign fin_ext  = {7'd0, final_next};
    assign occn_ext = {7'd0, occ_next};
    assign occ_w    = CMPW'(occ_reg);
    assign n_w      = CMPW'(q_count);

    // compare every valid cell against the key
    always_comb
    begin
        for (int i = 0; i < QUEUE_SLOTS; i++)
            match[i] = (OW'(i) < occ_reg) && (cell_reg[i] == key);
    end

    // mark cells at or behind the match
    always_comb
    begin
        after[0] = match[0];
        for (int i = 1; i < QUEUE_SLOTS; i++)
            after[i] = after[i-1] | match[i];
    end

    assign found = |match;
    assign few   = (q_word.func == kfc_pkg::FN_POPEX) && (occ_w < n_w);
    assign neff  = ((q_word.func == kfc_pkg::FN_POPUP) && (n_w > occ_w)) ? occ_w : n_w;

    // execute the command at the queue head, or continue a pop burst
    always_comb
    begin
        state_next  = state_reg;
        cell_next   = cell_reg;
        occ_next    = occ_reg;
        final_next  = final_reg;
        remain_next = remain_reg;
        res_next    = '0;
        done_next   = 1'b0;
        q_pop       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    done_next = 1'b1;
                    res_next.last = 1'b1;
                    case (q_word.func)
                        kfc_pkg::FN_ENQ, kfc_pkg::FN_REQ:
                        begin
                            if (found)
                                res_next.status = kfc_pkg::ST_DUP;
                            else if (occ_reg == OW'(QUEUE_SLOTS))
                                res_next.status = kfc_pkg::ST_FULL;
                            else
                            begin
                                occ_next = occ_reg + OW'(1);
                                if (q_word.func == kfc_pkg::FN_ENQ)
                                begin
                                    for (int i = 0; i < QUEUE_SLOTS; i++)
                                        if (OW'(i) == occ_reg)
                                            cell_next[i] = key;
                                end
                                else
                                begin
                                    for (int i = 1; i < QUEUE_SLOTS; i++)
                                        cell_next[i] = cell_reg[i-1];
                                    cell_next[0] = key;
                                end
                            end
                        end
                        kfc_pkg::FN_CAN:
                        begin
                            if (!found)
                                res_next.status = kfc_pkg::ST_ABSENT;
                            else
                            begin
                                occ_next = occ_reg - OW'(1);
                                for (int i = 0; i < QUEUE_SLOTS - 1; i++)
                                    if (after[i])
                                        cell_next[i] = cell_reg[i+1];
                            end
                        end
                        kfc_pkg::FN_POPEX, kfc_pkg::FN_POPUP:
                        begin
                            if (few)
                                res_next.status = kfc_pkg::ST_FEW;
                            else if (neff != '0)
                            begin
                                for (int i = 0; i < QUEUE_SLOTS - 1; i++)
                                    cell_next[i] = cell_reg[i+1];
                                final_next          = OW'(occ_w - neff);
                                occ_next            = final_next;
                                remain_next         = CW'(neff - CMPW'(1));
                                res_next.has_player = 1'b1;
                                res_next.popped_id  = head_id;
                                res_next.last       = (neff == CMPW'(1));
                                if (neff != CMPW'(1))
                                    state_next = S_POP;
                            end
                        end
                        kfc_pkg::FN_QRY:
                            res_next.is_waiting = found;
                        default:
                            res_next.status = kfc_pkg::ST_OK;
                    endcase
                    res_next.queue_size = occn_ext[6:0];
                end
            end
            S_POP:
            begin
                for (int i = 0; i < QUEUE_SLOTS - 1; i++)
                    cell_next[i] = cell_reg[i+1];
                done_next           = 1'b1;
                res_next.has_player = 1'b1;
                res_next.popped_id  = head_id;
                res_next.queue_size = fin_ext[6:0];
                res_next.last       = (remain_reg == CW'(1));
                remain_next         = remain_reg - CW'(1);
                if (remain_reg == CW'(1))
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cell_reg   <= cell_next;
        final_reg  <= final_next;
        remain_reg <= remain_next;
        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

@@ design/keyed_fifo_with_cancel_unit.sv @@
// Keyed FIFO with cancel. Commands pass through the front-end queue; the back end
// registers a result word in the cycle after it takes a command from that queue.
// Throughput: 1 command per cycle while no pop burst runs; pops emit one word
// per cycle, one per popped player, from the shifting cell row. A two-word command
// queue sets busy. Reset empties the queue; result words cannot be stalled.
`default_nettype none
`include "keyed_fifo_with_cancel_unit_assert.svh"
module keyed_fifo_with_cancel_unit #(
    parameter int QUEUE_SLOTS = kfc_pkg::QUEUE_SLOTS_DEF,
    parameter int KEY_BITS    = kfc_pkg::KEY_BITS_DEF,
    parameter int MAX_POP     = kfc_pkg::MAX_POP_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire kfc_pkg::in_word_t cmd,
    output logic                   done,
    output kfc_pkg::out_word_t     result
);

    localparam int CW = $clog2(MAX_POP + 1);

    logic              q_valid, q_pop;
    kfc_pkg::in_word_t q_word;
    logic [CW-1:0]     q_count;

    kfc_front #(.MAX_POP(MAX_POP), .CW(CW)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .q_valid(q_valid), .q_word(q_word), .q_count(q_count), .q_pop(q_pop)
    );

    kfc_back #(.QUEUE_SLOTS(QUEUE_SLOTS), .KEY_BITS(KEY_BITS),
               .MAX_POP(MAX_POP), .CW(CW)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_word(q_word),
        .q_count(q_count), .q_pop(q_pop), .done(done), .result(result)
    );

    `KFC_ASSERT_NOW(a_single_is_last, done && !result.has_player, result.last)
    `KFC_ASSERT_NEXT(a_burst_continues, done && !result.last, done && result.has_player)
    `KFC_ASSERT_NOW(a_err_no_id, done && (result.status != kfc_pkg::ST_OK), !result.has_player)

endmodule
`default_nettype wire

@@ sim/keyed_fifo_with_cancel_unit_tb.sv @@
// Testbench for the keyed FIFO with cancel: directed and random commands,
// each result word checked against an in-bench queue model. Depends on kfc_pkg.
`default_nettype none
module keyed_fifo_with_cancel_unit_tb;

    localparam int SLOTS     = kfc_pkg::QUEUE_SLOTS_DEF;
    localparam int POP_MAX   = kfc_pkg::MAX_POP_DEF;
    localparam int CMD_DEPTH = 1024;
    localparam int EXP_DEPTH = 1024;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    kfc_pkg::in_word_t  cmd;
    logic               done;
    kfc_pkg::out_word_t result;

    keyed_fifo_with_cancel_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    // model state: waiting keys, head at index 0
    logic [15:0]        waiting_keys [SLOTS];
    int                 waiting_cnt = 0;
    kfc_pkg::out_word_t expected_words [EXP_DEPTH];
    int                 exp_rd = 0;
    int                 exp_wr = 0;
    kfc_pkg::in_word_t  pending_cmds [CMD_DEPTH];
    int                 cmd_rd = 0;
    int                 cmd_wr = 0;
    int                 fail_count;
    int                 send_idle_pct;
    bit                 hold_send;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int find_waiting(logic [15:0] key);
        for (int i = 0; i < waiting_cnt; i++)
            if (waiting_keys[i] == key)
                return i;
        return -1;
    endfunction

    function automatic void expect_word(kfc_pkg::out_word_t w);
        expected_words[exp_wr % EXP_DEPTH] = w;
        exp_wr++;
    endfunction

    function automatic void queue_cmd(kfc_pkg::in_word_t c);
        pending_cmds[cmd_wr % CMD_DEPTH] = c;
        cmd_wr++;
    endfunction

    // drop the key at one position and close the gap
    function automatic void remove_at(int pos);
        for (int i = pos; i < waiting_cnt - 1; i++)
            waiting_keys[i] = waiting_keys[i+1];
        waiting_cnt--;
    endfunction

    // work out the result words that one command produces
    function automatic void predict_queue(kfc_pkg::in_word_t c);
        kfc_pkg::out_word_t w;
        int          n;
        int          pos;
        logic [15:0] got [POP_MAX];
        int          n_got;
        w     = '0;
        n_got = 0;
        n     = c.pop_count > POP_MAX ? POP_MAX : int'(c.pop_count);
        case (c.func)
            kfc_pkg::FN_ENQ, kfc_pkg::FN_REQ:
            begin
                if (find_waiting(c.player_id) >= 0)
                    w.status = kfc_pkg::ST_DUP;
                else if (waiting_cnt >= SLOTS)
                    w.status = kfc_pkg::ST_FULL;
                else if (c.func == kfc_pkg::FN_ENQ)
                begin
                    waiting_keys[waiting_cnt] = c.player_id;
                    waiting_cnt++;
                end
                else
                begin
                    for (int i = waiting_cnt; i > 0; i--)
                        waiting_keys[i] = waiting_keys[i-1];
                    waiting_keys[0] = c.player_id;
                    waiting_cnt++;
                end
            end
            kfc_pkg::FN_CAN:
            begin
                pos = find_waiting(c.player_id);
                if (pos < 0)
                    w.status = kfc_pkg::ST_ABSENT;
                else
                    remove_at(pos);
            end
            kfc_pkg::FN_POPEX, kfc_pkg::FN_POPUP:
            begin
                if (c.func == kfc_pkg::FN_POPEX && waiting_cnt < n)
                    w.status = kfc_pkg::ST_FEW;
                else
                begin
                    if (n > waiting_cnt)
                        n = waiting_cnt;
                    for (int i = 0; i < n; i++)
                    begin
                        got[i] = waiting_keys[0];
                        remove_at(0);
                    end
                    n_got = n;
                end
            end
            kfc_pkg::FN_QRY:
                w.is_waiting = find_waiting(c.player_id) >= 0;
            default: ;
        endcase
        if (n_got > 0)
        begin
            for (int i = 0; i < n_got; i++)
            begin
                w = '0;
                w.has_player = 1'b1;
                w.popped_id  = got[i];
                w.queue_size = 7'(waiting_cnt);
                w.last       = (i == n_got - 1);
                expect_word(w);
            end
        end
        else
        begin
            w.queue_size = 7'(waiting_cnt);
            w.last       = 1'b1;
            expect_word(w);
        end
    endfunction

    // take the word into the model at the edge that accepts it
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            predict_queue(cmd);
            cmd_rd++;
        end
    end

    // drive: present a word at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_wr != cmd_rd && !hold_send
                && $urandom_range(99) >= send_idle_pct)
            begin
                start <= 1'b1;
                cmd   <= pending_cmds[cmd_rd % CMD_DEPTH];
            end
            else
                start <= 1'b0;
        end
    end

    // check each result word against the oldest expectation
    always @(posedge clk)
    begin
        kfc_pkg::out_word_t e;
        if (rst_n && done)
        begin
            if (exp_wr == exp_rd)
            begin
                $error("unexpected result word %p", result);
                fail_count++;
            end
            else
            begin
                e = expected_words[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (result.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, result.status);
                    fail_count++;
                end
                if (result.has_player !== e.has_player)
                begin
                    $error("has_player exp %0d got %0d", e.has_player, result.has_player);
                    fail_count++;
                end
                if (result.popped_id !== e.popped_id)
                begin
                    $error("popped_id exp %0h got %0h", e.popped_id, result.popped_id);
                    fail_count++;
                end
                if (result.is_waiting !== e.is_waiting)
                begin
                    $error("is_waiting exp %0d got %0d", e.is_waiting, result.is_waiting);
                    fail_count++;
                end
                if (result.queue_size !== e.queue_size)
                begin
                    $error("queue_size exp %0d got %0d", e.queue_size, result.queue_size);
                    fail_count++;
                end
                if (result.last !== e.last)
                begin
                    $error("last exp %0d got %0d", e.last, result.last);
                    fail_count++;
                end
            end
        end
    end

    function automatic kfc_pkg::in_word_t make_cmd(logic [2:0] f, logic [15:0] k,
                                                   logic [4:0] n);
        kfc_pkg::in_word_t c;
        c.func      = f;
        c.player_id = k;
        c.pop_count = n;
        return c;
    endfunction

    // keys from a small pool so duplicates and cancels hit often
    function automatic logic [15:0] pick_key();
        if ($urandom_range(9) < 8)
            return 16'(16'h00F0 + $urandom_range(23));
        return 16'($urandom);
    endfunction

    task automatic wait_drained();
        while (cmd_wr != cmd_rd || start || exp_wr != exp_rd)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // queue count commands, with random content, in one phase
    task automatic add_random(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 35)
                queue_cmd(make_cmd(kfc_pkg::FN_ENQ, pick_key(), 5'd0));
            else if (r < 50)
                queue_cmd(make_cmd(kfc_pkg::FN_CAN, pick_key(), 5'd0));
            else if (r < 60)
                queue_cmd(make_cmd(kfc_pkg::FN_REQ, pick_key(), 5'd0));
            else if (r < 70)
                queue_cmd(make_cmd(kfc_pkg::FN_POPEX, pick_key(), 5'($urandom_range(6))));
            else if (r < 80)
                queue_cmd(make_cmd(kfc_pkg::FN_POPUP, pick_key(), 5'($urandom_range(31))));
            else if (r < 95)
                queue_cmd(make_cmd(kfc_pkg::FN_QRY, pick_key(), 5'($urandom)));
            else
                queue_cmd(make_cmd(3'($urandom_range(7)), 16'($urandom), 5'($urandom)));
        end
    endtask

    initial
    begin
        fail_count    = 0;
        send_idle_pct = 31;
        hold_send     = 1'b0;
        rst_n         = 1'b0;
        start         = 1'b0;
        cmd           = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty pops, extremes, duplicates, unused codes
        queue_cmd(make_cmd(kfc_pkg::FN_POPUP, 16'h0, 5'd5));
        queue_cmd(make_cmd(kfc_pkg::FN_POPEX, 16'h0, 5'd0));
        queue_cmd(make_cmd(kfc_pkg::FN_POPEX, 16'h0, 5'd1));
        queue_cmd(make_cmd(kfc_pkg::FN_ENQ, 16'h0000, 5'd0));
        queue_cmd(make_cmd(kfc_pkg::FN_ENQ, 16'hFFFF, 5'd31));
        queue_cmd(make_cmd(kfc_pkg::FN_ENQ, 16'hFFFF, 5'd0));
        queue_cmd(make_cmd(kfc_pkg::FN_REQ, 16'hA5A5, 5'd0));
        queue_cmd(make_cmd(kfc_pkg::FN_REQ, 16'h0000, 5'd0));
        queue_cmd(make_cmd(kfc_pkg::FN_QRY, 16'hA5A5, 5'd0));
        queue_cmd(make_cmd(kfc_pkg::FN_QRY, 16'h5A5A, 5'd0));
        queue_cmd(make_cmd(kfc_pkg::FN_CAN, 16'h5A5A, 5'd0));
        queue_cmd(make_cmd(kfc_pkg::FN_CAN, 16'h0000, 5'd0));
        queue_cmd(make_cmd(3'd6, 16'h1234, 5'd3));
        queue_cmd(make_cmd(3'd7, 16'hFFFF, 5'd31));
        queue_cmd(make_cmd(kfc_pkg::FN_POPEX, 16'h0, 5'd4));
        queue_cmd(make_cmd(kfc_pkg::FN_POPUP, 16'h0, 5'd31));
        wait_drained();

        // fill to full, hit full and dup, then pop above the cap
        for (int i = 0; i < SLOTS; i++)
            queue_cmd(make_cmd(kfc_pkg::FN_ENQ, 16'(16'h4000 + i), 5'd0));
        queue_cmd(make_cmd(kfc_pkg::FN_ENQ, 16'h7777, 5'd0));
        queue_cmd(make_cmd(kfc_pkg::FN_REQ, 16'h7777, 5'd0));
        queue_cmd(make_cmd(kfc_pkg::FN_ENQ, 16'h4003, 5'd0));
        queue_cmd(make_cmd(kfc_pkg::FN_POPEX, 16'h0, 5'd31));
        queue_cmd(make_cmd(kfc_pkg::FN_POPUP, 16'h0, 5'd17));
        wait_drained();
        for (int i = 0; i < 3; i++)
            queue_cmd(make_cmd(kfc_pkg::FN_POPUP, 16'h0, 5'd16));
        // hold off until every expected word has come
        wait_drained();

        add_random(120);
        wait_drained();
        send_idle_pct = 74;
        add_random(120);
        wait_drained();
        send_idle_pct = 0;
        add_random(120);
        wait_drained();
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+design
design/kfc_pkg.sv
design/kfc_front.sv
design/kfc_back.sv
design/keyed_fifo_with_cancel_unit.sv
sim/keyed_fifo_with_cancel_unit_tb.sv
